[src/lpc_pkg.sv]
// Shared types and constants for the LRU page cache.
`timescale 1ns / 1ps
package lpc_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam int PAGE_BITS_DEF = 31;

  localparam int PAGE_IN_W  = 31;
  localparam int SLOTS_W    = 11;
  localparam int CNT_W      = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [SLOTS_W-1:0]   SLOTS_RESET  = 11'd1024;
  localparam logic [REG_IDX_W-1:0] REG_SLOTS    = 1'b0;
  localparam logic [CNT_W-1:0]     CNT_SATURATE = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic                 hit;
    logic                 evicted_valid;
    logic [PAGE_IN_W-1:0] evicted_page;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     access_total;
  } result_t;

endpackage

[src/lpc_cfg.sv]
// Register port holding the active slot count.
`timescale 1ns / 1ps
module lpc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lpc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lpc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output logic [lpc_pkg::SLOTS_W-1:0]     slots_in_use
);
  import lpc_pkg::*;

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOTS_RESET;
    end else if (wr_en && reg_idx == REG_SLOTS) begin
      slots_in_use <= pwdata[SLOTS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_SLOTS) begin
      prdata = CFG_DATA_W'(slots_in_use);
    end
  end

endmodule

[src/lpc_engine.sv]
// Recency store in a circular memory with scan, shift-down and append sequencer.
`timescale 1ns / 1ps
module lpc_engine #(
  parameter int MAX_SLOTS = lpc_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_BITS = lpc_pkg::PAGE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [lpc_pkg::SLOTS_W-1:0]  slots_in_use,
  input  logic                         page_valid,
  output logic                         page_stall,
  input  logic [lpc_pkg::PAGE_IN_W-1:0] page_number,
  output logic                         res_valid,
  input  logic                         res_take,
  output lpc_pkg::result_t             res
);
  import lpc_pkg::*;

  localparam int AW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int OCC_W = $clog2(MAX_SLOTS + 1);
  localparam logic [AW-1:0] LAST_PTR = AW'(MAX_SLOTS - 1);

  logic [PAGE_BITS-1:0] mem [MAX_SLOTS];

  state_t               state, state_next;
  logic [PAGE_BITS-1:0] page;
  logic [PAGE_BITS-1:0] ev_page;
  logic [PAGE_BITS-1:0] rdata;
  logic [AW-1:0]        head;
  logic [AW-1:0]        rd_ptr;
  logic [AW-1:0]        dptr;
  logic [AW-1:0]        prev_ptr;
  logic [OCC_W-1:0]     occ;
  logic [OCC_W-1:0]     rd_cnt;
  logic                 dv;
  logic                 found;
  logic                 first;
  logic [CNT_W-1:0]     hit_cnt;
  logic [CNT_W-1:0]     acc_cnt;

  logic                 accept;
  logic                 issue;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic [PAGE_BITS-1:0] wdata;
  logic [31:0]          active;
  logic                 evict;
  logic [CNT_W-1:0]     hit_cnt_next;
  logic [CNT_W-1:0]     acc_cnt_next;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    if (slots_in_use == '0) begin
      active = 32'd1;
    end else if (32'(slots_in_use) > 32'(MAX_SLOTS)) begin
      active = 32'(MAX_SLOTS);
    end else begin
      active = 32'(slots_in_use);
    end
  end

  assign evict        = !found && (32'(occ) >= active) && (occ != '0);
  assign acc_cnt_next = (acc_cnt == CNT_SATURATE) ? acc_cnt : acc_cnt + CNT_W'(1);
  assign hit_cnt_next = (hit_cnt == CNT_SATURATE) ? hit_cnt : hit_cnt + CNT_W'(1);
  assign accept       = page_valid && !page_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (page_valid) begin
          state_next = (occ == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!issue && !dv) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_RESULT;
      ST_RESULT: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    page_stall = 1'b1;
    res_valid  = 1'b0;
    issue      = 1'b0;
    we         = 1'b0;
    waddr      = prev_ptr;
    wdata      = rdata;
    unique case (state)
      ST_IDLE:   page_stall = 1'b0;
      ST_SCAN: begin
        issue = (rd_cnt != occ);
        we    = dv && found;
      end
      ST_FINISH: begin
        we    = 1'b1;
        waddr = found ? prev_ptr : rd_ptr;
        wdata = page;
      end
      ST_RESULT: res_valid = 1'b1;
      default:   page_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (issue) begin
      rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      head    <= '0;
      occ     <= '0;
      hit_cnt <= '0;
      acc_cnt <= '0;
      dv      <= 1'b0;
      found   <= 1'b0;
      first   <= 1'b0;
    end else begin
      state <= state_next;
      dv    <= issue;
      if (accept) begin
        found <= 1'b0;
        first <= 1'b1;
      end else if (dv) begin
        first <= 1'b0;
        if (!found && rdata == page) begin
          found <= 1'b1;
        end
      end
      if (state == ST_FINISH) begin
        acc_cnt <= acc_cnt_next;
        if (found) begin
          hit_cnt <= hit_cnt_next;
        end
        if (evict) begin
          head <= ptr_inc(head);
        end else if (!found) begin
          occ <= occ + OCC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page    <= PAGE_BITS'(page_number);
      rd_ptr  <= head;
      rd_cnt  <= '0;
      ev_page <= '0;
    end else begin
      if (issue) begin
        rd_ptr <= ptr_inc(rd_ptr);
        rd_cnt <= rd_cnt + OCC_W'(1);
      end
      if (dv) begin
        prev_ptr <= dptr;
        if (first) begin
          ev_page <= rdata;
        end
      end
    end
    dptr <= rd_ptr;
    if (state == ST_FINISH) begin
      res.hit           <= found;
      res.evicted_valid <= evict;
      res.evicted_page  <= evict ? PAGE_IN_W'(ev_page) : '0;
      res.hit_total     <= found ? hit_cnt_next : hit_cnt;
      res.access_total  <= acc_cnt_next;
    end
  end

endmodule

[src/lru_page_cache_simulator.sv]
// Top level of the fully associative LRU page cache with result register.
//
// Usage: each transaction on the page channel (page_valid / page_stall)
// carries one page number. The block looks it up among the resident pages,
// held oldest first in a circular memory, and returns one transaction on
// the result channel (result_valid / result_stall): hit flag, eviction flag
// and evicted page, and the saturating hit and access totals.
// Scan: the single-read-port memory is read one resident entry per cycle,
// and the scan also shifts newer entries down over a hit. A page is
// accepted only while the sequencer is idle, so one page is looked up at
// a time and the next is taken once its result has gone to the register.
// A finished result sits in the output register, so a new page is taken
// while the receiver stalls; the sequencer only waits if a second result
// is ready before the first has gone. Reset clears occupancy, both totals
// and the channels and sets the slot count register to 1024. The user must
// make register writes while the block is idle; it does not enforce this.
`timescale 1ns / 1ps
module lru_page_cache_simulator #(
  parameter int MAX_SLOTS = lpc_pkg::MAX_SLOTS_DEF,
  parameter int PAGE_BITS = lpc_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lpc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [lpc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [lpc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            page_valid,
  output logic                            page_stall,
  input  logic [lpc_pkg::PAGE_IN_W-1:0]   page_number,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            hit,
  output logic                            evicted_valid,
  output logic [lpc_pkg::PAGE_IN_W-1:0]   evicted_page,
  output logic [lpc_pkg::CNT_W-1:0]       hit_total,
  output logic [lpc_pkg::CNT_W-1:0]       access_total
);
  import lpc_pkg::*;

  logic [SLOTS_W-1:0] slots_in_use;
  logic               res_valid;
  logic               res_take;
  result_t            res;
  result_t            out_reg;

  lpc_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .slots_in_use (slots_in_use)
  );

  lpc_engine #(
    .MAX_SLOTS (MAX_SLOTS),
    .PAGE_BITS (PAGE_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .slots_in_use (slots_in_use),
    .page_valid   (page_valid),
    .page_stall   (page_stall),
    .page_number  (page_number),
    .res_valid    (res_valid),
    .res_take     (res_take),
    .res          (res)
  );

  assign res_take = res_valid && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_reg <= res;
    end
  end

  assign hit           = out_reg.hit;
  assign evicted_valid = out_reg.evicted_valid;
  assign evicted_page  = out_reg.evicted_page;
  assign hit_total     = out_reg.hit_total;
  assign access_total  = out_reg.access_total;

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(hit && evicted_valid))
    else $error("hit and eviction in one transaction");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !evicted_valid) |-> (evicted_page == '0))
    else $error("evicted page not zero without eviction");

  a_totals_order: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (hit_total <= access_total))
    else $error("hit total above access total");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (page_valid && !page_stall) |=> page_stall)
    else $error("second page taken while one is in flight");

endmodule
